[rtl/cls_pkg.sv]
// Shared types, constants and helper functions for the cyclic load profile sequencer.
// Used by the controller, the datapath, the divider and the top level.
package cls_pkg;

    localparam int OP_W     = 3;
    localparam int ROT_W    = 24;
    localparam int SPD_W    = 17;
    localparam int TQ_W     = 18;
    localparam int CNT_W    = 16;
    localparam int CFG_W    = 40;
    localparam int ADDR_W   = 3;
    localparam int TAB_W    = 18;
    localparam int ST_W     = 19;
    localparam int SLOPE_W  = 21;
    localparam int X_W      = 25;
    localparam int DIFF_W   = 26;
    localparam int PROD_W   = 47;
    localparam int ACC_W    = 49;
    localparam int NUM_W    = 20;
    localparam int DEN_W    = 18;
    localparam int DCNT_W   = 5;
    localparam int NPTS     = 5;
    localparam int SCALE    = 41;
    localparam int ROUND    = 1 << 11;
    localparam int FRAC     = 12;
    localparam int IN_DW    = 32;
    localparam int OUT_DW   = 56;

    localparam logic signed [ACC_W-1:0] TQ_MAX = ACC_W'(131071);
    localparam logic signed [ACC_W-1:0] TQ_MIN = -ACC_W'(131072);

    typedef enum logic [ADDR_W-1:0] {
        REG_CYCLE_COUNT     = 3'd0,
        REG_PEAK_ROTATION   = 3'd1,
        REG_PEAK_TORQUE     = 3'd2,
        REG_RUN_SPEED       = 3'd3,
        REG_ROTATION_POINTS = 3'd4,
        REG_TORQUE_POINTS   = 3'd5
    } reg_idx_t;

    typedef enum logic [OP_W-1:0] {
        OP_NONE   = 3'd0,
        OP_START  = 3'd1,
        OP_UPDATE = 3'd2,
        OP_STOP   = 3'd3,
        OP_PAUSE  = 3'd4
    } op_t;

    typedef enum logic [2:0] {
        MODE_IDLE     = 3'd0,
        MODE_WORK     = 3'd1,
        MODE_COMPLETE = 3'd2,
        MODE_WAIT     = 3'd3,
        MODE_CLEAN    = 3'd4
    } mode_t;

    typedef enum logic [2:0] {
        ACT_NONE,
        ACT_START,
        ACT_UPDATE,
        ACT_CLEAN,
        ACT_PAUSE,
        ACT_RESUME,
        ACT_WAITSTOP,
        ACT_TOIDLE
    } act_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_TAB,
        ST_DIVGO,
        ST_DIVRUN,
        ST_RISE,
        ST_UPD,
        ST_MUL,
        ST_INT,
        ST_OUT
    } state_t;

    typedef struct packed {
        act_t act;
        logic tab_step;
        logic div_go;
        logic slope_wr;
        logic rise;
        logic upd;
        logic mul;
        logic interp;
        logic out_load;
    } cls_cmd_t;

    typedef struct packed {
        mode_t mode;
        logic  cnt_zero;
        logic  k_zero;
        logic  k_last;
        logic  div_done;
        logic  interp;
    } cls_stat_t;

    function automatic logic [TQ_W-1:0] sat_tq(input logic signed [ACC_W-1:0] v);
        logic [TQ_W-1:0] r;
        if (v > TQ_MAX) begin
            r = TQ_MAX[TQ_W-1:0];
        end else if (v < TQ_MIN) begin
            r = TQ_MIN[TQ_W-1:0];
        end else begin
            r = v[TQ_W-1:0];
        end
        return r;
    endfunction

endpackage

[rtl/cls_ctrl.sv]
// Controller state machine of the cyclic load profile sequencer.
// Depends on cls_pkg; drives the datapath by commands and reads its status.
module cls_ctrl import cls_pkg::*; (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_tvalid,
    output logic            s_tready,
    input  logic [OP_W-1:0] opcode,
    output logic            m_tvalid,
    input  logic            m_tready,
    input  cls_stat_t       stat,
    output cls_cmd_t        cmd
);

    state_t state_reg, state_next;
    logic   mvalid_reg, mvalid_next;
    act_t   act_dec;
    logic   accept;

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign m_tvalid = mvalid_reg;

    always_comb begin
        act_dec = ACT_NONE;
        case (stat.mode)
            MODE_IDLE: begin
                if (opcode == OP_START && !stat.cnt_zero) act_dec = ACT_START;
            end
            MODE_WORK, MODE_COMPLETE: begin
                if (opcode == OP_UPDATE)     act_dec = ACT_UPDATE;
                else if (opcode == OP_STOP)  act_dec = ACT_CLEAN;
                else if (opcode == OP_PAUSE) act_dec = ACT_PAUSE;
            end
            MODE_WAIT: begin
                if (opcode == OP_START)      act_dec = ACT_RESUME;
                else if (opcode == OP_STOP)  act_dec = ACT_WAITSTOP;
            end
            default: begin
                if (opcode == OP_UPDATE) act_dec = ACT_TOIDLE;
            end
        endcase
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    case (act_dec)
                        ACT_START:  state_next = ST_TAB;
                        ACT_RESUME: state_next = ST_RISE;
                        ACT_UPDATE: state_next = ST_UPD;
                        default:    state_next = ST_OUT;
                    endcase
                end
            end
            ST_TAB:    state_next = stat.k_zero ? ST_TAB : ST_DIVGO;
            ST_DIVGO:  state_next = ST_DIVRUN;
            ST_DIVRUN: begin
                if (stat.div_done) state_next = stat.k_last ? ST_RISE : ST_TAB;
            end
            ST_RISE:   state_next = ST_OUT;
            ST_UPD:    state_next = stat.interp ? ST_MUL : ST_OUT;
            ST_MUL:    state_next = ST_INT;
            ST_INT:    state_next = ST_OUT;
            ST_OUT: begin
                if (!mvalid_reg || m_tready) state_next = ST_IDLE;
            end
            default:   state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        cmd = '0;
        cmd.act = ACT_NONE;
        case (state_reg)
            ST_IDLE:   cmd.act      = accept ? act_dec : ACT_NONE;
            ST_TAB:    cmd.tab_step = 1'b1;
            ST_DIVGO:  cmd.div_go   = 1'b1;
            ST_DIVRUN: cmd.slope_wr = stat.div_done;
            ST_RISE:   cmd.rise     = 1'b1;
            ST_UPD:    cmd.upd      = 1'b1;
            ST_MUL:    cmd.mul      = 1'b1;
            ST_INT:    cmd.interp   = 1'b1;
            ST_OUT:    cmd.out_load = !mvalid_reg || m_tready;
            default:   cmd.act      = ACT_NONE;
        endcase
    end

    always_comb begin
        if (cmd.out_load) begin
            mvalid_next = 1'b1;
        end else if (m_tready) begin
            mvalid_next = 1'b0;
        end else begin
            mvalid_next = mvalid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_IDLE;
            mvalid_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            mvalid_reg <= mvalid_next;
        end
    end

endmodule

[rtl/cls_div.sv]
// Iterative restoring divider, one quotient bit per cycle, truncating toward zero.
// Depends on cls_pkg; a zero divisor gives a zero quotient.
module cls_div import cls_pkg::*; (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      go,
    input  logic signed [SLOPE_W-1:0] num,
    input  logic signed [ST_W-1:0]    den,
    output logic                      done,
    output logic signed [SLOPE_W-1:0] quo
);

    logic                     busy_reg, done_reg;
    logic [DCNT_W-1:0]        cnt_reg;
    logic [NUM_W-1:0]         n_reg, n_next;
    logic [DEN_W-1:0]         d_reg, r_reg, r_next;
    logic                     neg_reg, dz_reg;
    logic signed [SLOPE_W-1:0] quo_reg;
    logic [DEN_W:0]           r_sh, r_sub;
    logic [SLOPE_W-1:0]       num_abs;
    logic [ST_W-1:0]          den_abs;
    logic [SLOPE_W-1:0]       q_ext;

    assign num_abs = num[SLOPE_W-1] ? SLOPE_W'(-num) : SLOPE_W'(num);
    assign den_abs = den[ST_W-1] ? ST_W'(-den) : ST_W'(den);

    assign r_sh  = {r_reg, n_reg[NUM_W-1]};
    assign r_sub = r_sh - {1'b0, d_reg};

    always_comb begin
        if (!r_sub[DEN_W]) begin
            r_next = r_sub[DEN_W-1:0];
            n_next = {n_reg[NUM_W-2:0], 1'b1};
        end else begin
            r_next = r_sh[DEN_W-1:0];
            n_next = {n_reg[NUM_W-2:0], 1'b0};
        end
    end

    assign q_ext = {1'b0, n_next};
    assign done  = done_reg;
    assign quo   = quo_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (go) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == DCNT_W'(NUM_W - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (go) begin
            n_reg   <= num_abs[NUM_W-1:0];
            d_reg   <= den_abs[DEN_W-1:0];
            r_reg   <= '0;
            neg_reg <= num[SLOPE_W-1] ^ den[ST_W-1];
            dz_reg  <= (den == '0);
        end else if (busy_reg) begin
            n_reg <= n_next;
            r_reg <= r_next;
            if (cnt_reg == DCNT_W'(NUM_W - 1)) begin
                if (dz_reg) begin
                    quo_reg <= '0;
                end else if (neg_reg) begin
                    quo_reg <= -$signed(q_ext);
                end else begin
                    quo_reg <= $signed(q_ext);
                end
            end
        end
    end

endmodule

[rtl/cls_dp.sv]
// Datapath of the cyclic load profile sequencer: configuration, tables, segment state,
// interpolation and the output word register. Depends on cls_pkg and cls_div.
module cls_dp import cls_pkg::*; #(
    parameter int POINTS = 5
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_wr_en,
    input  logic [ADDR_W-1:0]  cfg_addr,
    input  logic [CFG_W-1:0]   cfg_wdata,
    input  logic signed [ROT_W-1:0] rotation,
    input  cls_cmd_t           cmd,
    output cls_stat_t          stat,
    output logic [OUT_DW-1:0]  out_word
);

    localparam int KW = $clog2(POINTS);
    localparam int TW = (POINTS > 2) ? $clog2(POINTS - 1) : 1;

    logic [CNT_W-1:0] cfg_count_reg, cfg_peak_rot_reg, cfg_peak_tq_reg, cfg_speed_reg;
    logic [CFG_W-1:0] cfg_rpts_reg, cfg_tpts_reg;

    mode_t                     mode_reg;
    logic [CNT_W-1:0]          rem_reg;
    logic [KW-1:0]             seg_reg, k_reg;
    logic                      fall_reg, rst_lvl_reg;
    logic [CNT_W-1:0]          held_peak_reg, held_speed_reg;
    logic [TAB_W-1:0]          tor0_reg;
    logic [TAB_W-1:0]          cur_rot_reg, cur_tor_reg, prev_rot_reg, prev_tor_reg;
    logic [TAB_W-1:0]          rs_tab [0:POINTS-2];
    logic [TAB_W-1:0]          re_tab [0:POINTS-2];
    logic [TAB_W-1:0]          ts_tab [0:POINTS-2];
    logic signed [SLOPE_W-1:0] sl_tab [0:POINTS-2];
    logic [TAB_W-1:0]          ss_rot_reg, se_rot_reg;
    logic signed [ST_W-1:0]    st_reg;
    logic signed [SLOPE_W-1:0] sl_reg;
    logic signed [SPD_W-1:0]   speed_reg;
    logic [TQ_W-1:0]           torque_reg;
    logic signed [ROT_W-1:0]   rot_reg;
    logic signed [X_W-1:0]     x_reg;
    logic signed [PROD_W-1:0]  prod_reg;
    logic [OUT_DW-1:0]         out_reg;

    // Table build.
    logic [7:0]            k_ext;
    logic [10:0]           sh_amt;
    logic [CFG_W-1:0]      r_sh, t_sh;
    logic [7:0]            pnt_r, pnt_t;
    logic [29:0]           scl_r, scl_t;
    logic [TAB_W-1:0]      new_rot, new_tor;
    logic [TW-1:0]         km1;
    logic signed [ST_W-1:0] d_tor, d_rot;
    logic signed [SLOPE_W-1:0] div_num, div_quo;
    logic                  div_done;

    assign k_ext  = 8'(k_reg);
    assign sh_amt = {k_ext, 3'b000};
    assign r_sh   = cfg_rpts_reg >> sh_amt;
    assign t_sh   = cfg_tpts_reg >> sh_amt;
    assign pnt_r  = (k_ext < 8'(NPTS)) ? r_sh[7:0] : 8'd0;
    assign pnt_t  = (k_ext < 8'(NPTS)) ? t_sh[7:0] : 8'd0;
    assign scl_r  = 30'(cfg_peak_rot_reg) * 30'(pnt_r) * 30'(SCALE) + 30'(ROUND);
    assign scl_t  = 30'(cfg_peak_tq_reg) * 30'(pnt_t) * 30'(SCALE) + 30'(ROUND);
    assign new_rot = TAB_W'(scl_r >> FRAC);
    assign new_tor = TAB_W'(scl_t >> FRAC);
    assign km1     = TW'(k_reg - 1'b1);

    assign d_tor   = $signed({1'b0, cur_tor_reg}) - $signed({1'b0, prev_tor_reg});
    assign d_rot   = $signed({1'b0, cur_rot_reg}) - $signed({1'b0, prev_rot_reg});
    assign div_num = {d_tor, 2'b00};

    cls_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .go      (cmd.div_go),
        .num     (div_num),
        .den     (d_rot),
        .done    (div_done),
        .quo     (div_quo)
    );

    // Update decisions.
    logic                   at_peak, at_bottom, interp;
    logic [CNT_W-1:0]       rem_dec;
    logic signed [X_W-1:0]  x_val, peak_x, rot_x, end_x;
    logic [KW-1:0]          seg_inc;
    logic                   adv, ld_inc;
    logic [TW-1:0]          lidx;
    logic                   lneg;
    logic [TAB_W-1:0]       l_rs, l_re, l_ts;
    logic signed [SLOPE_W-1:0] l_sl;
    logic signed [ST_W-1:0] l_st;
    logic [TQ_W-1:0]        tor0_sat;
    logic signed [SPD_W-1:0] spd_pos;

    assign peak_x    = $signed({{(X_W-CNT_W){1'b0}}, held_peak_reg});
    assign rot_x     = X_W'(rot_reg);
    assign end_x     = $signed({{(X_W-TAB_W){1'b0}}, se_rot_reg});
    assign at_peak   = rot_x >= peak_x;
    assign at_bottom = fall_reg && (rot_reg <= 0);
    assign interp    = !at_peak && !at_bottom;
    assign rem_dec   = rem_reg - 1'b1;
    assign x_val     = fall_reg ? (peak_x - rot_x) : rot_x;
    assign seg_inc   = seg_reg + 1'b1;
    assign adv       = (x_val >= end_x) && (seg_reg < KW'(POINTS - 1));
    assign ld_inc    = adv && (seg_inc < KW'(POINTS - 1));
    assign lidx      = (cmd.upd && interp) ? seg_inc[TW-1:0] : '0;
    assign lneg      = cmd.upd && (at_peak || fall_reg);
    assign l_rs      = rs_tab[lidx];
    assign l_re      = re_tab[lidx];
    assign l_ts      = ts_tab[lidx];
    assign l_sl      = lneg ? -sl_tab[lidx] : sl_tab[lidx];
    assign l_st      = lneg ? -$signed({1'b0, l_ts}) : $signed({1'b0, l_ts});
    assign tor0_sat  = sat_tq(ACC_W'($signed({1'b0, tor0_reg})));
    assign spd_pos   = $signed({1'b0, held_speed_reg});

    // Interpolation.
    logic signed [DIFF_W-1:0] diff;
    logic signed [ACC_W-1:0]  acc, acc_q;

    assign diff  = DIFF_W'(x_reg) - $signed({{(DIFF_W-TAB_W){1'b0}}, ss_rot_reg});
    assign acc   = ACC_W'($signed({st_reg, 2'b00})) + ACC_W'(prod_reg);
    assign acc_q = acc >>> 2;

    assign stat.mode     = mode_reg;
    assign stat.cnt_zero = (cfg_count_reg == '0);
    assign stat.k_zero   = (k_reg == '0);
    assign stat.k_last   = (k_reg == KW'(POINTS - 1));
    assign stat.div_done = div_done;
    assign stat.interp   = interp;
    assign out_word      = out_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_count_reg    <= '0;
            cfg_peak_rot_reg <= '0;
            cfg_peak_tq_reg  <= '0;
            cfg_speed_reg    <= '0;
            cfg_rpts_reg     <= '0;
            cfg_tpts_reg     <= '0;
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                REG_CYCLE_COUNT:     cfg_count_reg    <= cfg_wdata[CNT_W-1:0];
                REG_PEAK_ROTATION:   cfg_peak_rot_reg <= cfg_wdata[CNT_W-1:0];
                REG_PEAK_TORQUE:     cfg_peak_tq_reg  <= cfg_wdata[CNT_W-1:0];
                REG_RUN_SPEED:       cfg_speed_reg    <= cfg_wdata[CNT_W-1:0];
                REG_ROTATION_POINTS: cfg_rpts_reg     <= cfg_wdata;
                REG_TORQUE_POINTS:   cfg_tpts_reg     <= cfg_wdata;
                default:             cfg_count_reg    <= cfg_count_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg    <= MODE_IDLE;
            rem_reg     <= '0;
            seg_reg     <= '0;
            fall_reg    <= 1'b0;
            rst_lvl_reg <= 1'b0;
            speed_reg   <= '0;
            torque_reg  <= '0;
            ss_rot_reg  <= '0;
            se_rot_reg  <= '0;
            st_reg      <= '0;
            sl_reg      <= '0;
            k_reg       <= '0;
        end else begin
            case (cmd.act)
                ACT_START: begin
                    rem_reg <= cfg_count_reg;
                    k_reg   <= '0;
                end
                ACT_CLEAN: begin
                    mode_reg    <= MODE_CLEAN;
                    speed_reg   <= '0;
                    torque_reg  <= '0;
                    rst_lvl_reg <= 1'b1;
                end
                ACT_PAUSE:    mode_reg <= MODE_COMPLETE;
                ACT_WAITSTOP: begin
                    mode_reg    <= MODE_CLEAN;
                    rst_lvl_reg <= 1'b1;
                end
                ACT_TOIDLE: begin
                    mode_reg    <= MODE_IDLE;
                    rst_lvl_reg <= 1'b0;
                    rem_reg     <= '0;
                    seg_reg     <= '0;
                    fall_reg    <= 1'b0;
                end
                default: mode_reg <= mode_reg;
            endcase
            if (cmd.tab_step && k_reg == '0) k_reg <= k_reg + 1'b1;
            if (cmd.slope_wr) k_reg <= k_reg + 1'b1;
            if (cmd.rise) begin
                mode_reg    <= MODE_WORK;
                rst_lvl_reg <= 1'b1;
                seg_reg     <= '0;
                fall_reg    <= 1'b0;
                ss_rot_reg  <= l_rs;
                se_rot_reg  <= l_re;
                st_reg      <= l_st;
                sl_reg      <= l_sl;
                speed_reg   <= spd_pos;
                torque_reg  <= tor0_sat;
            end
            if (cmd.upd) begin
                rst_lvl_reg <= 1'b0;
                if (at_peak) begin
                    fall_reg   <= 1'b1;
                    seg_reg    <= '0;
                    ss_rot_reg <= l_rs;
                    se_rot_reg <= l_re;
                    st_reg     <= l_st;
                    sl_reg     <= l_sl;
                    speed_reg  <= -spd_pos;
                    torque_reg <= tor0_sat;
                end else if (at_bottom) begin
                    rem_reg  <= rem_dec;
                    fall_reg <= 1'b0;
                    seg_reg  <= '0;
                    if (rem_dec == '0) begin
                        mode_reg    <= MODE_CLEAN;
                        speed_reg   <= '0;
                        torque_reg  <= '0;
                        rst_lvl_reg <= 1'b1;
                    end else if (mode_reg == MODE_WORK) begin
                        ss_rot_reg  <= rs_tab[0];
                        se_rot_reg  <= re_tab[0];
                        st_reg      <= $signed({1'b0, ts_tab[0]});
                        sl_reg      <= sl_tab[0];
                        speed_reg   <= spd_pos;
                        torque_reg  <= tor0_sat;
                    end else begin
                        speed_reg  <= '0;
                        torque_reg <= '0;
                        mode_reg   <= MODE_WAIT;
                    end
                end else if (adv) begin
                    seg_reg <= seg_inc;
                    if (ld_inc) begin
                        ss_rot_reg <= l_rs;
                        se_rot_reg <= l_re;
                        st_reg     <= l_st;
                        sl_reg     <= l_sl;
                    end
                end
            end
            if (cmd.interp) torque_reg <= sat_tq(acc_q);
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.act == ACT_START) begin
            held_peak_reg  <= cfg_peak_rot_reg;
            held_speed_reg <= cfg_speed_reg;
        end
        if (cmd.act == ACT_UPDATE) rot_reg <= rotation;
        if (cmd.tab_step) begin
            cur_rot_reg  <= new_rot;
            cur_tor_reg  <= new_tor;
            prev_rot_reg <= cur_rot_reg;
            prev_tor_reg <= cur_tor_reg;
            if (k_reg == '0) tor0_reg <= new_tor;
        end
        if (cmd.div_go) begin
            rs_tab[km1] <= prev_rot_reg;
            re_tab[km1] <= cur_rot_reg;
            ts_tab[km1] <= prev_tor_reg;
        end
        if (cmd.slope_wr) sl_tab[km1] <= div_quo;
        if (cmd.upd) x_reg <= x_val;
        if (cmd.mul) prod_reg <= PROD_W'(sl_reg * diff);
        if (cmd.out_load) begin
            out_reg <= {1'b0, rem_reg, rst_lvl_reg, torque_reg, speed_reg, mode_reg};
        end
    end

endmodule

[rtl/cyclic_load_profile_sequencer.sv]
// Top level of the cyclic load profile sequencer.
// Depends on cls_pkg, cls_ctrl, cls_dp (with cls_div).
//
// Usage: write the six configuration registers through cfg_wr_en, cfg_addr and
// cfg_wdata while the block is idle, then send command words on the s_ channel.
// Every accepted word gives exactly one result word on the m_ channel, which
// reports the run mode, the speed and torque commands, the device reset level
// and the cycles still to run.
// A start from idle first builds the segment tables, with the serial divider
// working out the slope of each segment in turn; an update passes through a
// multiply and an interpolation step only when the rotation lies inside a segment.
// One word is processed at a time; the next word is accepted once the result
// of the previous one sits in the output register.
// Reset returns the block to idle with all commands at zero and no result pending.
// When the receiver stalls, the result word holds on m_tdata and the block
// accepts one more word, then waits until the held word is taken.
module cyclic_load_profile_sequencer import cls_pkg::*; #(
    parameter int POINTS = 5
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_wr_en,
    input  logic [ADDR_W-1:0]  cfg_addr,
    input  logic [CFG_W-1:0]   cfg_wdata,
    input  logic               s_tvalid,
    output logic               s_tready,
    // opcode [2:0], rotation [26:3], zero fill
    input  logic [IN_DW-1:0]   s_tdata,
    output logic               m_tvalid,
    input  logic               m_tready,
    // mode [2:0], speed_command [19:3], torque_command [37:20], hold_reset [38],
    // cycles_left [54:39], zero fill
    output logic [OUT_DW-1:0]  m_tdata
);

    cls_cmd_t  cmd;
    cls_stat_t stat;

    cls_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .opcode   (s_tdata[OP_W-1:0]),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    cls_dp #(.POINTS(POINTS)) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .rotation  ($signed(s_tdata[OP_W+ROT_W-1:OP_W])),
        .cmd       (cmd),
        .stat      (stat),
        .out_word  (m_tdata)
    );

endmodule

[rtl/cls_chk.sv]
// Port-level checker for the cyclic load profile sequencer, bound to the top level.
// Depends on cls_pkg for field widths and mode codes.
module cls_chk import cls_pkg::*; (
    input logic              aclk,
    input logic              aresetn,
    input logic              m_tvalid,
    input logic              m_tready,
    input logic [OUT_DW-1:0] m_tdata
);

    logic [2:0] mode_f;
    assign mode_f = m_tdata[2:0];

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result word changed while stalled");

    a_rst: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result word valid after reset");

    a_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && mode_f == MODE_IDLE |-> m_tdata[38] == 1'b0 && m_tdata[54:39] == '0)
        else $error("idle word with reset level or cycles left");

    a_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && mode_f == MODE_CLEAN |->
            m_tdata[38] == 1'b1 && m_tdata[19:3] == '0 && m_tdata[37:20] == '0)
        else $error("clean word with live commands");

endmodule

bind cyclic_load_profile_sequencer cls_chk u_cls_chk (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
